/* hw/rtl/spring_gradient_position_step_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the spring gradient step
// Concurrent checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef SPRING_GRADIENT_POSITION_STEP_ASSERT_SVH
`define SPRING_GRADIENT_POSITION_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define SGPS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sgps check failed");
`define SGPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sgps check failed");
`else
`define SGPS_ASSERT_NOW(lbl, ante, cons)
`define SGPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/sgps_pkg.sv */
// ---------------------------------------------------------------------------
// sgps_pkg
// Shared constants, types and helpers of the spring gradient step.
// ---------------------------------------------------------------------------
package sgps_pkg;

	localparam int MAX_FRIENDS = 1024;

	localparam int MUL_AW = 48;
	localparam int MUL_BW = 36;
	localparam int MUL_PW = MUL_AW + MUL_BW;
	localparam int SQ_IW  = 66;
	localparam int SQ_RW  = 33;
	localparam int DIV_NW = 64;
	localparam int DIV_DW = 34;

	localparam logic [34:0] LCG_A   = 35'h5DEECE66D;
	localparam logic [47:0] LCG_C   = 48'hB;
	localparam logic [15:0] RNG_LOW = 16'h330E;
	localparam logic [DIV_DW-1:0] JIT_DIV = 34'd10;

	localparam int S_TDATA_W = 176;
	localparam int M_TDATA_W = 128;
	localparam int CFG_IW    = 2;
	localparam int CFG_DW    = 32;

	localparam logic [CFG_IW-1:0] REG_NEAR_COUNT   = 2'd0;
	localparam logic [CFG_IW-1:0] REG_FAR_FRACTION = 2'd1;
	localparam logic [CFG_IW-1:0] REG_MAX_PRESSURE = 2'd2;
	localparam logic [CFG_IW-1:0] REG_RNG_SEED     = 2'd3;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SEL, ST_DRAW, ST_DRAW_W, ST_DIFF,
		ST_SQX, ST_SQX_W, ST_SQY, ST_SQY_W, ST_SQRT, ST_SQRT_W,
		ST_CLAMP, ST_MX, ST_MX_W, ST_DX, ST_DX_W,
		ST_MY, ST_MY_W, ST_DY, ST_DY_W,
		ST_JMUL, ST_JMUL_W, ST_JDIV, ST_JDIV_W,
		ST_ACC, ST_FIN, ST_EMIT
	} st_t;

	typedef enum logic [1:0] {TAG_FAR, TAG_JX, TAG_JY} tag_t;

	function automatic logic [32:0] abs33(input logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
		if (v > 41'sh07F_FFFF_FFFF)
			return 40'sh7F_FFFF_FFFF;
		else if (v < -41'sh080_0000_0000)
			return 40'sh80_0000_0000;
		return v[39:0];
	endfunction

	function automatic logic [31:0] sat32(input logic signed [40:0] v);
		if (v > 41'sh000_7FFF_FFFF)
			return 32'h7FFF_FFFF;
		else if (v < -41'sh000_8000_0000)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

endpackage

/* hw/rtl/sgps_mul.sv */
// ---------------------------------------------------------------------------
// sgps_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module sgps_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sgps_pkg::MUL_AW-1:0] a,
	input  logic [sgps_pkg::MUL_BW-1:0] b,
	output logic                       done,
	output logic [sgps_pkg::MUL_PW-1:0] p
);
	import sgps_pkg::*;

	logic [MUL_PW-1:0] acc_q;
	logic [MUL_PW-1:0] a_q;
	logic [MUL_BW-1:0] b_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(MUL_BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= MUL_PW'(a);
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0])
				acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

/* hw/rtl/sgps_sqrt.sv */
// ---------------------------------------------------------------------------
// sgps_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ---------------------------------------------------------------------------
module sgps_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sgps_pkg::SQ_IW-1:0] rad,
	output logic                      done,
	output logic [sgps_pkg::SQ_RW-1:0] root
);
	import sgps_pkg::*;

	logic [SQ_IW-1:0] rad_q;
	logic [35:0]      rem_q;
	logic [SQ_RW-1:0] root_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [35:0]      remn;
	logic [35:0]      trial;

	assign remn  = {rem_q[33:0], rad_q[SQ_IW-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(SQ_RW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (remn >= trial) begin
				rem_q  <= remn - trial;
				root_q <= {root_q[SQ_RW-2:0], 1'b1};
			end else begin
				rem_q  <= remn;
				root_q <= {root_q[SQ_RW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* hw/rtl/sgps_div.sv */
// ---------------------------------------------------------------------------
// sgps_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module sgps_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sgps_pkg::DIV_NW-1:0] n,
	input  logic [sgps_pkg::DIV_DW-1:0] d,
	output logic                       done,
	output logic [sgps_pkg::DIV_NW-1:0] q
);
	import sgps_pkg::*;

	logic [DIV_NW-1:0] nq_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] d_q;
	logic [6:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   r2;
	logic              ge;

	assign r2 = {rem_q, nq_q[DIV_NW-1]};
	assign ge = r2 >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= n;
			rem_q <= '0;
			d_q   <= d;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DW'(r2 - {1'b0, d_q}) : r2[DIV_DW-1:0];
			nq_q  <= {nq_q[DIV_NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign q    = nq_q;

endmodule

/* hw/rtl/spring_gradient_position_step.sv */
// ---------------------------------------------------------------------------
// spring_gradient_position_step
// Spring-force gradient and position step for one object of a 2D layout.
// ---------------------------------------------------------------------------
// Usage: the friends of one object enter on the s_ channel, one per item,
// closest first; s_tlast marks the last friend, s_tuser is near mode.
// On the last item one result (gradient and moved position) leaves on m_.
// Registers are written through cfg_we/cfg_idx/cfg_data; the user must
// write them only while idle, as the block does not enforce it. A seed
// write reloads the random generator. The block takes one item at a time.
// A used friend takes two squares and two products on the bit-serial
// multiplier, a square root and two divisions. A far-mode draw adds one
// more multiplication. A too-close friend spends two draws, products and
// divisions by ten in place of the products and divisions. A skipped
// friend goes to ST_FIN without adding to the sums; a last item also passes
// through ST_EMIT, which loads the result into the output register.
// The result waits in an output register; the next item is taken while it
// waits, and only a later last item stalls until m_tready frees the slot.
// Reset clears the sums, loads default registers and seeds the generator.
// ---------------------------------------------------------------------------
`include "spring_gradient_position_step_assert.svh"

module spring_gradient_position_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// friend_rank, self_x, self_y, friend_x, friend_y, target_dist, zero pad
	input  logic [sgps_pkg::S_TDATA_W-1:0] s_tdata,
	// near_mode
	input  logic                          s_tuser,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// grad_x, grad_y, new_x, new_y
	output logic [sgps_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                          cfg_we,
	input  logic [sgps_pkg::CFG_IW-1:0]    cfg_idx,
	input  logic [sgps_pkg::CFG_DW-1:0]    cfg_data
);
	import sgps_pkg::*;

	st_t  st_q, st_d;
	tag_t tag_q;

	logic [10:0] near_count_q;
	logic [16:0] far_frac_q;
	logic [30:0] max_press_q;
	logic [47:0] rng_q;

	logic [9:0]         rank_q;
	logic signed [31:0] sx_q, sy_q, fx_q, fy_q;
	logic [30:0]        tgt_q;
	logic               near_q, last_q;

	logic signed [32:0] dx_q, dy_q;
	logic [65:0]        qsum_q;
	logic [32:0]        dcur_q;
	logic signed [31:0] df_q;
	logic signed [33:0] tx_q, ty_q;
	logic [63:0]        prod_q;
	logic               neg_q;
	logic signed [39:0] sum_x_q, sum_y_q;
	logic               m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic              mul_start, mul_done;
	logic [MUL_AW-1:0] mul_a;
	logic [MUL_BW-1:0] mul_b;
	logic [MUL_PW-1:0] mul_p;
	logic              sq_start, sq_done;
	logic [SQ_RW-1:0]  sq_root;
	logic              div_start, div_done;
	logic [DIV_NW-1:0] div_n, div_q;
	logic [DIV_DW-1:0] div_d;

	logic               accept;
	logic [47:0]        rng_nxt;
	logic [32:0]        adx, ady;
	logic [31:0]        adf, ac;
	logic [39:0]        dcur100;
	logic               close;
	logic signed [33:0] df34, mp34, dfc;
	logic signed [33:0] qs, qsn;
	logic signed [40:0] qx41, qy41;
	logic [31:0]        gx, gy, nx, ny;

	sgps_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
	);

	sgps_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.rad(qsum_q), .done(sq_done), .root(sq_root)
	);

	sgps_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.n(div_n), .d(div_d), .done(div_done), .q(div_q)
	);

	assign s_tready = (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign rng_nxt  = mul_p[47:0] + LCG_C;
	assign adx      = abs33(dx_q);
	assign ady      = abs33(dy_q);
	assign adf      = abs32(df_q);
	assign ac       = abs32({~rng_q[47], rng_q[46:16]});
	assign dcur100  = ({7'b0, dcur_q} << 6) + ({7'b0, dcur_q} << 5) + ({7'b0, dcur_q} << 2);
	assign close    = dcur100 < {9'b0, tgt_q};
	assign df34     = $signed({1'b0, dcur_q}) - $signed({3'b0, tgt_q});
	assign mp34     = $signed({3'b0, max_press_q});
	assign dfc      = (df34 > mp34) ? mp34 : ((df34 < -mp34) ? -mp34 : df34);
	assign qs       = $signed({2'b0, div_q[31:0]});
	assign qsn      = neg_q ? -qs : qs;

	assign qx41 = ($signed({sum_x_q[39], sum_x_q}) + (sum_x_q[39] ? 41'sd3 : 41'sd0)) >>> 2;
	assign qy41 = ($signed({sum_y_q[39], sum_y_q}) + (sum_y_q[39] ? 41'sd3 : 41'sd0)) >>> 2;
	assign gx   = sat32($signed({sum_x_q[39], sum_x_q}));
	assign gy   = sat32($signed({sum_y_q[39], sum_y_q}));
	assign nx   = sat32($signed({{9{sx_q[31]}}, sx_q}) + qx41);
	assign ny   = sat32($signed({{9{sy_q[31]}}, sy_q}) + qy41);

	always_comb begin
		st_d      = st_q;
		mul_start = 1'b0;
		sq_start  = 1'b0;
		div_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_n     = '0;
		div_d     = '0;
		unique case (st_q)
			ST_IDLE: if (s_tvalid) st_d = ST_SEL;
			ST_SEL: begin
				if ({1'b0, rank_q} >= 11'(MAX_FRIENDS))
					st_d = ST_FIN;
				else if ({1'b0, rank_q} < near_count_q)
					st_d = ST_DIFF;
				else if (near_q)
					st_d = ST_FIN;
				else
					st_d = ST_DRAW;
			end
			ST_DRAW: begin
				mul_start = 1'b1;
				mul_a     = rng_q;
				mul_b     = MUL_BW'(LCG_A);
				st_d      = ST_DRAW_W;
			end
			ST_DRAW_W: if (mul_done) begin
				if (tag_q != TAG_FAR)
					st_d = ST_JMUL;
				else if ({1'b0, rng_nxt} > {far_frac_q, 32'b0})
					st_d = ST_FIN;
				else
					st_d = ST_DIFF;
			end
			ST_DIFF: st_d = ST_SQX;
			ST_SQX: begin
				mul_start = 1'b1;
				mul_a     = MUL_AW'(adx);
				mul_b     = MUL_BW'(adx);
				st_d      = ST_SQX_W;
			end
			ST_SQX_W: if (mul_done) st_d = ST_SQY;
			ST_SQY: begin
				mul_start = 1'b1;
				mul_a     = MUL_AW'(ady);
				mul_b     = MUL_BW'(ady);
				st_d      = ST_SQY_W;
			end
			ST_SQY_W: if (mul_done) st_d = ST_SQRT;
			ST_SQRT: begin
				sq_start = 1'b1;
				st_d     = ST_SQRT_W;
			end
			ST_SQRT_W: if (sq_done) st_d = ST_CLAMP;
			ST_CLAMP: begin
				if (close)
					st_d = ST_DRAW;
				else if (dcur_q == '0)
					st_d = ST_ACC;
				else
					st_d = ST_MX;
			end
			ST_MX: begin
				mul_start = 1'b1;
				mul_a     = MUL_AW'(adx);
				mul_b     = MUL_BW'(adf);
				st_d      = ST_MX_W;
			end
			ST_MX_W: if (mul_done) st_d = ST_DX;
			ST_DX: begin
				div_start = 1'b1;
				div_n     = prod_q;
				div_d     = DIV_DW'(dcur_q);
				st_d      = ST_DX_W;
			end
			ST_DX_W: if (div_done) st_d = ST_MY;
			ST_MY: begin
				mul_start = 1'b1;
				mul_a     = MUL_AW'(ady);
				mul_b     = MUL_BW'(adf);
				st_d      = ST_MY_W;
			end
			ST_MY_W: if (mul_done) st_d = ST_DY;
			ST_DY: begin
				div_start = 1'b1;
				div_n     = prod_q;
				div_d     = DIV_DW'(dcur_q);
				st_d      = ST_DY_W;
			end
			ST_DY_W: if (div_done) st_d = ST_ACC;
			ST_JMUL: begin
				mul_start = 1'b1;
				mul_a     = MUL_AW'(ac);
				mul_b     = MUL_BW'(tgt_q);
				st_d      = ST_JMUL_W;
			end
			ST_JMUL_W: if (mul_done) st_d = ST_JDIV;
			ST_JDIV: begin
				div_start = 1'b1;
				div_n     = DIV_NW'(prod_q[63:32]);
				div_d     = JIT_DIV;
				st_d      = ST_JDIV_W;
			end
			ST_JDIV_W: if (div_done) st_d = (tag_q == TAG_JX) ? ST_DRAW : ST_ACC;
			ST_ACC: st_d = ST_FIN;
			ST_FIN: st_d = last_q ? ST_EMIT : ST_IDLE;
			ST_EMIT: if (!m_tvalid_q || m_tready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			tag_q        <= TAG_FAR;
			near_count_q <= 11'd16;
			far_frac_q   <= 17'd32768;
			max_press_q  <= 31'd65536;
			rng_q        <= {32'b0, RNG_LOW};
			sum_x_q      <= '0;
			sum_y_q      <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_NEAR_COUNT:   near_count_q <= cfg_data[10:0];
					REG_FAR_FRACTION: far_frac_q   <= cfg_data[16:0];
					REG_MAX_PRESSURE: max_press_q  <= cfg_data[30:0];
					REG_RNG_SEED:     rng_q        <= {cfg_data, RNG_LOW};
					default: ;
				endcase
			end
			if (accept)
				tag_q <= TAG_FAR;
			if (st_q == ST_CLAMP && close)
				tag_q <= TAG_JX;
			if (st_q == ST_JDIV_W && div_done && tag_q == TAG_JX)
				tag_q <= TAG_JY;
			if (st_q == ST_DRAW_W && mul_done)
				rng_q <= rng_nxt;
			if (st_q == ST_ACC) begin
				sum_x_q <= sat40($signed({sum_x_q[39], sum_x_q}) + 41'(tx_q));
				sum_y_q <= sat40($signed({sum_y_q[39], sum_y_q}) + 41'(ty_q));
			end
			if (st_q == ST_EMIT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
				sum_x_q    <= '0;
				sum_y_q    <= '0;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rank_q <= s_tdata[9:0];
			sx_q   <= s_tdata[41:10];
			sy_q   <= s_tdata[73:42];
			fx_q   <= s_tdata[105:74];
			fy_q   <= s_tdata[137:106];
			tgt_q  <= s_tdata[168:138];
			near_q <= s_tuser;
			last_q <= s_tlast;
		end
		if (st_q == ST_DIFF) begin
			dx_q <= 33'(fx_q) - 33'(sx_q);
			dy_q <= 33'(fy_q) - 33'(sy_q);
		end
		if (mul_done)
			prod_q <= mul_p[63:0];
		if (st_q == ST_SQX_W && mul_done)
			qsum_q <= mul_p[65:0];
		if (st_q == ST_SQY_W && mul_done)
			qsum_q <= qsum_q + mul_p[65:0];
		if (st_q == ST_SQRT_W && sq_done)
			dcur_q <= sq_root;
		if (st_q == ST_CLAMP) begin
			df_q <= dfc[31:0];
			tx_q <= '0;
			ty_q <= '0;
		end
		if (st_q == ST_MX)
			neg_q <= df_q[31] ^ dx_q[32];
		if (st_q == ST_MY)
			neg_q <= df_q[31] ^ dy_q[32];
		if (st_q == ST_JMUL)
			neg_q <= ~rng_q[47];
		if (st_q == ST_DX_W && div_done)
			tx_q <= qsn;
		if (st_q == ST_DY_W && div_done)
			ty_q <= qsn;
		if (st_q == ST_JDIV_W && div_done) begin
			if (tag_q == TAG_JX)
				tx_q <= qsn;
			else
				ty_q <= qsn;
		end
		if (st_q == ST_EMIT && (!m_tvalid_q || m_tready))
			m_tdata_q <= {ny, nx, gy, gx};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`SGPS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, st_q != ST_IDLE)
	`SGPS_ASSERT_NOW(a_sums_cleared, $rose(m_tvalid_q), sum_x_q == '0 && sum_y_q == '0)
	`SGPS_ASSERT_NOW(a_div_nonzero, div_start, div_d != '0)

endmodule
